// ===== rtl/gstd_pkg.sv =====
// Shared types, constants and tables of the Goertzel signed tone detector.
package gstd_pkg;

	// Fixed-point layout
	localparam int SAMPLE_BITS  = 12;
	localparam int ACC_BITS     = 48;
	localparam int FRAC_BITS    = 16;
	localparam int COEFF_BITS   = 19;
	localparam int TRIG_BITS    = 18;
	localparam int ANGLE_BITS   = 16;
	localparam int MAG_BITS     = 32;
	localparam int PROJ_BITS    = ACC_BITS + 2;
	localparam int VEC_BITS     = PROJ_BITS + 4;
	localparam int TURN_BITS    = 32;
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_BITS    = $clog2(CORDIC_STEPS);

	localparam logic [STEP_BITS-1:0]  STEP_LAST    = STEP_BITS'(CORDIC_STEPS - 1);
	localparam logic [TURN_BITS-1:0]  HALF_TURN    = 32'h8000_0000;
	localparam logic [TURN_BITS-1:0]  ANGLE_ROUND  = 32'h0000_8000;
	localparam logic [31:0]           INV_GAIN_Q32 = 32'd2608131496;
	localparam logic [ANGLE_BITS:0]   QUARTER_TURN = 17'd16384;

	// Register map, one 32-bit word each
	typedef enum logic [1:0] {
		REG_COEFF  = 2'd0,
		REG_COSINE = 2'd1,
		REG_SINE   = 2'd2,
		REG_REF    = 2'd3
	} reg_idx_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		B_IDLE,
		B_COS,
		B_SIN,
		B_PREP,
		B_ROT,
		B_GLO,
		B_GHI,
		B_FIN
	} back_state_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   last_sample;
	} item_t;

	typedef struct packed {
		logic signed [MAG_BITS-1:0]   signed_magnitude;
		logic signed [ANGLE_BITS-1:0] phase;
		logic                         was_negated;
	} result_t;

	typedef struct packed {
		logic signed [COEFF_BITS-1:0] coeff;
		logic signed [TRIG_BITS-1:0]  cosine;
		logic signed [TRIG_BITS-1:0]  sine;
		logic signed [ANGLE_BITS-1:0] ref_phase;
	} cfg_t;

	// Final resonator state of one block
	typedef struct packed {
		logic signed [ACC_BITS-1:0] q1;
		logic signed [ACC_BITS-1:0] q2;
	} pair_t;

	typedef struct packed {
		logic  wr;
		pair_t data;
	} queue_wr_t;

	typedef struct packed {
		logic  empty;
		pair_t head;
	} queue_rd_t;

	// Arctangent of 2^-n in units of 2^-32 turn
	function automatic logic [TURN_BITS-1:0] arc_angle(input logic [STEP_BITS-1:0] idx);
		logic [TURN_BITS-1:0] a;
		case (idx)
			5'd0:    a = 32'h2000_0000;
			5'd1:    a = 32'h12E4_051E;
			5'd2:    a = 32'h09FB_385B;
			5'd3:    a = 32'h0511_11D4;
			5'd4:    a = 32'h028B_0D43;
			5'd5:    a = 32'h0145_D7E1;
			5'd6:    a = 32'h00A2_F61E;
			5'd7:    a = 32'h0051_7C55;
			5'd8:    a = 32'h0028_BE53;
			5'd9:    a = 32'h0014_5F2F;
			5'd10:   a = 32'h000A_2F98;
			5'd11:   a = 32'h0005_17CC;
			5'd12:   a = 32'h0002_8BE6;
			5'd13:   a = 32'h0001_45F3;
			5'd14:   a = 32'h0000_A2FA;
			5'd15:   a = 32'h0000_517D;
			5'd16:   a = 32'h0000_28BE;
			5'd17:   a = 32'h0000_145F;
			5'd18:   a = 32'h0000_0A30;
			5'd19:   a = 32'h0000_0518;
			5'd20:   a = 32'h0000_028C;
			5'd21:   a = 32'h0000_0146;
			5'd22:   a = 32'h0000_00A3;
			5'd23:   a = 32'h0000_0051;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/gstd_front.sv =====
// Front end: resonator recurrence per sample, hands block state to the queue.
module gstd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  gstd_pkg::item_t   item,
	input  gstd_pkg::cfg_t    cfg,
	output gstd_pkg::queue_wr_t qwr
);
	import gstd_pkg::*;

	localparam int RPROD_BITS = ACC_BITS + COEFF_BITS;

	logic signed [ACC_BITS-1:0]   delay_one_q;
	logic signed [ACC_BITS-1:0]   delay_two_q;
	logic signed [RPROD_BITS-1:0] rmul;
	logic signed [ACC_BITS-1:0]   nxt;

	// q0 = floor(coeff*q1 / 2^16) - q2 + sample*2^16, wrapping
	assign rmul = delay_one_q * cfg.coeff;
	assign nxt  = rmul[ACC_BITS+FRAC_BITS-1:FRAC_BITS] - delay_two_q
		+ ACC_BITS'({item.sample, FRAC_BITS'(0)});

	// Hand the closing state of a block to the back end
	always_comb begin
		qwr.wr      = accept && item.last_sample;
		qwr.data.q1 = nxt;
		qwr.data.q2 = delay_one_q;
	end

	// Advance the delay line; clear it at the end of a block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_one_q <= '0;
			delay_two_q <= '0;
		end else if (accept) begin
			if (item.last_sample) begin
				delay_one_q <= '0;
				delay_two_q <= '0;
			end else begin
				delay_two_q <= delay_one_q;
				delay_one_q <= nxt;
			end
		end
	end

endmodule

// ===== rtl/gstd_queue.sv =====
// Small queue of finished block states between front and back ends.
module gstd_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gstd_pkg::queue_wr_t qwr,
	output logic                full,
	input  logic                rd,
	output gstd_pkg::queue_rd_t qrd
);
	import gstd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pair_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign qrd.empty = (count_q == '0);
	assign qrd.head  = mem_q[rd_ptr_q];

	// Store an entry
	always_ff @(posedge clk) begin
		if (qwr.wr) begin
			mem_q[wr_ptr_q] <= qwr.data;
		end
	end

	// Move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qwr.wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (qwr.wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !qwr.wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/gstd_back.sv =====
// Back end: projection, CORDIC magnitude and phase, reference test, result register.
module gstd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  gstd_pkg::cfg_t      cfg,
	input  gstd_pkg::queue_rd_t qrd,
	output logic                q_rd,
	input  logic                pop,
	output logic                empty,
	output gstd_pkg::result_t   result
);
	import gstd_pkg::*;

	localparam int PPROD_BITS = ACC_BITS + TRIG_BITS;
	localparam int HI_BITS    = VEC_BITS - 32;
	localparam int SUM_BITS   = HI_BITS + 32 + 1;
	localparam int FULL_BITS  = SUM_BITS - FRAC_BITS;

	back_state_t state_q, state_d;
	logic        res_ld;

	logic signed [ACC_BITS-1:0]  q1_q, q2_q;
	logic signed [PROJ_BITS-1:0] re_q, im_q;
	logic signed [VEC_BITS-1:0]  vx_q, vy_q;
	logic [TURN_BITS-1:0]        ang_q;
	logic [STEP_BITS-1:0]        step_q;
	logic                        zero_q;
	logic [31:0]                 plo_q;
	logic [HI_BITS+31:0]         phi_q;
	result_t                     res_q;
	logic                        res_valid_q;

	logic signed [TRIG_BITS-1:0]  pcoef;
	logic signed [PPROD_BITS-1:0] pmul;
	logic signed [PROJ_BITS-1:0]  proj;
	logic signed [VEC_BITS-1:0]   re_x, im_x, dx, dy;
	logic                         vy_pos;
	logic [31:0]                  ga;
	logic [63:0]                  gmul;
	logic [SUM_BITS-1:0]          mag_sum;
	logic [FULL_BITS-1:0]         mag_full;
	logic [MAG_BITS-1:0]          mag;
	logic [TURN_BITS-1:0]         ang_rnd;
	logic signed [ANGLE_BITS-1:0] ph;
	logic signed [ANGLE_BITS:0]   diff;
	logic [ANGLE_BITS:0]          absd;
	logic                         neg;
	result_t                      fin;

	// Shared projection multiplier: q2*cos, then q2*sin
	assign pcoef = (state_q == B_COS) ? cfg.cosine : cfg.sine;
	assign pmul  = q2_q * pcoef;
	assign proj  = pmul[PROJ_BITS+FRAC_BITS-1:FRAC_BITS];

	// One CORDIC micro-rotation
	assign re_x   = VEC_BITS'(re_q);
	assign im_x   = VEC_BITS'(im_q);
	assign dx     = vx_q >>> step_q;
	assign dy     = vy_q >>> step_q;
	assign vy_pos = !vy_q[VEC_BITS-1] && (vy_q != '0);

	// Gain correction, low half then high half through one 32x32 multiplier
	assign ga   = (state_q == B_GLO) ? vx_q[31:0] : 32'(vx_q[VEC_BITS-1:32]);
	assign gmul = 64'(ga) * 64'(INV_GAIN_Q32);

	// Round, saturate, phase and reference test
	always_comb begin
		mag_sum  = SUM_BITS'(phi_q) + SUM_BITS'(plo_q) + SUM_BITS'(ANGLE_ROUND);
		mag_full = mag_sum[SUM_BITS-1:FRAC_BITS];
		mag      = (|mag_full[FULL_BITS-1:MAG_BITS-1]) ? {1'b0, {(MAG_BITS-1){1'b1}}}
			: {1'b0, mag_full[MAG_BITS-2:0]};
		ang_rnd  = ang_q + ANGLE_ROUND;
		ph       = ang_rnd[TURN_BITS-1:TURN_BITS-ANGLE_BITS];
		diff     = {cfg.ref_phase[ANGLE_BITS-1], cfg.ref_phase} - {ph[ANGLE_BITS-1], ph};
		absd     = diff[ANGLE_BITS] ? (ANGLE_BITS+1)'(-diff) : (ANGLE_BITS+1)'(diff);
		neg      = absd < QUARTER_TURN;
		if (zero_q) begin
			fin = '0;
		end else begin
			fin.signed_magnitude = neg ? -mag : mag;
			fin.phase            = ph;
			fin.was_negated      = neg;
		end
	end

	// Next state and handshakes
	always_comb begin
		state_d = state_q;
		q_rd    = 1'b0;
		res_ld  = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!qrd.empty) begin
					q_rd    = 1'b1;
					state_d = B_COS;
				end
			end
			B_COS:  state_d = B_SIN;
			B_SIN:  state_d = B_PREP;
			B_PREP: state_d = ((re_q == '0) && (im_q == '0)) ? B_FIN : B_ROT;
			B_ROT: begin
				if (step_q == STEP_LAST) begin
					state_d = B_GLO;
				end
			end
			B_GLO:  state_d = B_GHI;
			B_GHI:  state_d = B_FIN;
			B_FIN: begin
				if (!res_valid_q || pop) begin
					res_ld  = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Hold state, step count and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_PREP) begin
				step_q <= '0;
			end else if (state_q == B_ROT) begin
				step_q <= step_q + 1'b1;
			end
			if (res_ld) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_rd) begin
					q1_q <= qrd.head.q1;
					q2_q <= qrd.head.q2;
				end
			end
			B_COS: re_q <= PROJ_BITS'(q1_q) - proj;
			B_SIN: im_q <= proj;
			B_PREP: begin
				zero_q <= (re_q == '0) && (im_q == '0);
				if (re_q[PROJ_BITS-1]) begin
					vx_q  <= -re_x;
					vy_q  <= -im_x;
					ang_q <= HALF_TURN;
				end else begin
					vx_q  <= re_x;
					vy_q  <= im_x;
					ang_q <= '0;
				end
			end
			B_ROT: begin
				if (vy_pos) begin
					vx_q  <= vx_q + dy;
					vy_q  <= vy_q - dx;
					ang_q <= ang_q + arc_angle(step_q);
				end else begin
					vx_q  <= vx_q - dy;
					vy_q  <= vy_q + dx;
					ang_q <= ang_q - arc_angle(step_q);
				end
			end
			B_GLO: plo_q <= gmul[63:32];
			B_GHI: phi_q <= gmul[HI_BITS+31:0];
			default: ;
		endcase
		if (res_ld) begin
			res_q <= fin;
		end
	end

	assign empty  = !res_valid_q;
	assign result = res_q;

endmodule

// ===== rtl/goertzel_signed_tone_detector.sv =====
// Top level of the Goertzel signed tone detector: register port, front, queue, back.
//
//  channel   handshake            word
//  -------   ------------------   ----------------------------------------
//  samples   push / full          item: sample, last_sample
//  results   pop / empty          result: signed_magnitude, phase, was_negated
//  config    psel/penable/pwrite  paddr 4*index, pwdata/prdata 32 bits
//
// The front end takes one sample per cycle while the queue is not full: one 48x19
// multiply-add per sample. A block's closing state goes into a QUEUE_DEPTH-entry
// queue; full rises only while that queue is full. The back end takes the next
// block from the queue only when done with the last: load, two projections, setup,
// 24 CORDIC rotations, two gain products, finish; a zero vector skips to finish.
// It may wait for the result register to be popped. arst_n clears the resonator,
// the queue, the sequencer and the result flag, and loads register reset values.
module goertzel_signed_tone_detector #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  gstd_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output gstd_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import gstd_pkg::*;

	cfg_t      cfg_q;
	reg_idx_t  reg_idx;
	logic      cfg_wr;
	logic      accept;
	queue_wr_t qwr;
	queue_rd_t qrd;
	logic      q_full;
	logic      q_rd;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coeff     <= '0;
			cfg_q.cosine    <= TRIG_BITS'(65536);
			cfg_q.sine      <= '0;
			cfg_q.ref_phase <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_COEFF:  cfg_q.coeff     <= pwdata[COEFF_BITS-1:0];
				REG_COSINE: cfg_q.cosine    <= pwdata[TRIG_BITS-1:0];
				REG_SINE:   cfg_q.sine      <= pwdata[TRIG_BITS-1:0];
				REG_REF:    cfg_q.ref_phase <= pwdata[ANGLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read back, sign-extended
	always_comb begin
		case (reg_idx)
			REG_COEFF:  prdata = 32'(cfg_q.coeff);
			REG_COSINE: prdata = 32'(cfg_q.cosine);
			REG_SINE:   prdata = 32'(cfg_q.sine);
			REG_REF:    prdata = 32'(cfg_q.ref_phase);
			default:    prdata = '0;
		endcase
	end

	assign full   = q_full;
	assign accept = push && !q_full;

	gstd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg_q),
		.qwr    (qwr)
	);

	gstd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qwr    (qwr),
		.full   (q_full),
		.rd     (q_rd),
		.qrd    (qrd)
	);

	gstd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.qrd    (qrd),
		.q_rd   (q_rd),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	// Queue never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qwr.wr |-> !q_full)
		else $error("block state written into a full queue");

	// Back end never drains an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !qrd.empty)
		else $error("back end read an empty queue");

	// A last sample leaves a block state waiting in the queue
	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.last_sample) |=> !qrd.empty)
		else $error("last sample did not reach the queue");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the Goertzel signed tone detector with a bit-true tone predictor.
`timescale 1ns / 1ps

module tb_top;
	import gstd_pkg::*;

	localparam int SETTLE_CYCLES = 40;     // margin for the back end to finish a block
	localparam int STALL_LIMIT   = 3000;
	localparam int RANDOM_WORDS  = 1950;
	localparam int PHASE_WORDS   = 150;
	localparam logic [31:0] INV_GAIN = 32'd2608131496;
	localparam result_t SILENT = '0;

	// Arctangent of 2^-n in 2^-32 turn, step n at bits [32n +: 32]
	localparam logic [24*32-1:0] ATAN_TURNS = {
		32'h0000_0051, 32'h0000_00A3, 32'h0000_0146, 32'h0000_028C,
		32'h0000_0518, 32'h0000_0A30, 32'h0000_145F, 32'h0000_28BE,
		32'h0000_517D, 32'h0000_A2FA, 32'h0001_45F3, 32'h0002_8BE6,
		32'h0005_17CC, 32'h000A_2F98, 32'h0014_5F2F, 32'h0028_BE53,
		32'h0051_7C55, 32'h00A2_F61E, 32'h0145_D7E1, 32'h028B_0D43,
		32'h0511_11D4, 32'h09FB_385B, 32'h12E4_051E, 32'h2000_0000
	};

	typedef struct {
		bit          is_write;
		reg_idx_t    reg_sel;
		logic [31:0] value;
		item_t       word;
		bit          known;
		result_t     known_res;
	} stim_row_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        push    = 1'b0;
	item_t       item    = '0;
	logic        pop     = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [3:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic        full;
	logic        empty;
	result_t     result;
	logic [31:0] prdata;
	logic        pready;

	// Tone predictor state and register copy
	cfg_t                       regs;
	logic signed [ACC_BITS-1:0] q_one;
	logic signed [ACC_BITS-1:0] q_two;
	result_t                    pending_results[$];

	int errors       = 0;
	int stuck_cycles = 0;
	int stall_left   = 0;
	bit calm         = 1'b0;

	goertzel_signed_tone_detector dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always #2 clk = ~clk;

	// Gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Advance the resonator by one sample; on a last sample form magnitude and phase
	function automatic bit goertzel_step(input item_t w, output result_t r);
		logic signed [127:0] wide_a, wide_b, prod;
		logic [ACC_BITS-1:0] nxt;
		longint              s1, proj, re_v, im_v, vx, vy, dx, dy;
		logic [31:0]         ang, ang_r, mag;
		logic [63:0]         mu, hpart;
		logic signed [15:0]  ph;
		int                  ref_v, ph_v, diff;
		bit                  neg;
		r = SILENT;
		wide_a = 128'(q_one);
		wide_b = 128'(regs.coeff);
		prod = (wide_a * wide_b) >>> FRAC_BITS;
		nxt = prod[ACC_BITS-1:0] - q_two + (ACC_BITS'(w.sample) << FRAC_BITS);
		q_two = q_one;
		q_one = nxt;
		if (!w.last_sample) return 1'b0;

		// Project the closing state onto real and imaginary parts
		s1 = longint'(q_one);
		wide_a = 128'(q_two);
		wide_b = 128'(regs.cosine);
		prod = (wide_a * wide_b) >>> FRAC_BITS;
		proj = prod[63:0];
		re_v = s1 - proj;
		wide_b = 128'(regs.sine);
		prod = (wide_a * wide_b) >>> FRAC_BITS;
		im_v = prod[63:0];
		q_one = '0;
		q_two = '0;
		if (re_v == 0 && im_v == 0) return 1'b1;

		// Vectoring rotation, pre-rotated by a half turn for negative real part
		vx = re_v;
		vy = im_v;
		ang = '0;
		if (vx < 0) begin
			vx = -vx;
			vy = -vy;
			ang = 32'h8000_0000;
		end
		for (int n = 0; n < CORDIC_STEPS; n++) begin
			dx = vx >>> n;
			dy = vy >>> n;
			if (vy > 0) begin
				vx = vx + dy;
				vy = vy - dx;
				ang = ang + ATAN_TURNS[n*32 +: 32];
			end else begin
				vx = vx - dy;
				vy = vy + dx;
				ang = ang - ATAN_TURNS[n*32 +: 32];
			end
		end

		// Remove the rotation gain, round to sample units, saturate
		mu = vx;
		hpart = (mu >> 32) * 64'(INV_GAIN) + ((64'(mu[31:0]) * 64'(INV_GAIN)) >> 32);
		hpart = (hpart + 64'h8000) >> 16;
		mag = (hpart > 64'd2147483647) ? 32'h7FFF_FFFF : hpart[31:0];

		// Round the angle and compare with the reference without unwrapping
		ang_r = ang + 32'h0000_8000;
		ph = ang_r[31:16];
		ref_v = int'(regs.ref_phase);
		ph_v = int'(ph);
		diff = ref_v - ph_v;
		if (diff < 0) diff = -diff;
		neg = diff < 16384;

		r.signed_magnitude = neg ? 32'd0 - mag : mag;
		r.phase = ph;
		r.was_negated = neg;
		return 1'b1;
	endfunction

	function automatic stim_row_t sample_row(input int s, input bit l, input bit known,
		input result_t res);
		stim_row_t r;
		r.is_write = 1'b0;
		r.reg_sel = REG_COEFF;
		r.value = '0;
		r.word.sample = SAMPLE_BITS'(s);
		r.word.last_sample = l;
		r.known = known;
		r.known_res = res;
		return r;
	endfunction

	function automatic stim_row_t reg_row(input reg_idx_t sel, input int v);
		stim_row_t r;
		r.is_write = 1'b1;
		r.reg_sel = sel;
		r.value = v;
		r.word = '0;
		r.known = 1'b0;
		r.known_res = SILENT;
		return r;
	endfunction

	// Random register value: ends of the field or anything, sometimes junk above the field
	function automatic logic [31:0] pick_reg_value(input int width);
		logic [31:0] mask, v;
		int          span, r;
		span = 1 << (width - 1);
		mask = (32'h1 << width) - 1;
		r = $urandom_range(0, 7);
		if (r == 0) v = -span;
		else if (r == 1) v = span - 1;
		else v = int'($urandom_range(0, 2 * span - 1)) - span;
		if ($urandom_range(0, 3) == 0) v = (v & mask) | ($urandom() & ~mask);
		return v;
	endfunction

	// Push one sample word and record what it should produce
	task automatic feed_word(input item_t w, input bit known, input result_t known_res);
		result_t predicted;
		int      gap;
		bit      has;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		has = goertzel_step(w, predicted);
		if (known) pending_results.push_back(known_res);
		else if (has) pending_results.push_back(predicted);
	endtask

	// Register write: setup then access; keep the bus for a following write
	task automatic write_reg(input reg_idx_t sel, input logic [31:0] v, input bit more);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (!more) begin
			psel    <= 1'b0;
			penable <= 1'b0;
			pwrite  <= 1'b0;
		end
		case (sel)
			REG_COEFF:  regs.coeff     = v[COEFF_BITS-1:0];
			REG_COSINE: regs.cosine    = v[TRIG_BITS-1:0];
			REG_SINE:   regs.sine      = v[TRIG_BITS-1:0];
			REG_REF:    regs.ref_phase = v[ANGLE_BITS-1:0];
			default: ;
		endcase
	endtask

	// Hold input, drain all results, let the back end go idle
	task automatic quiesce();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: random pop stalls, compare, watchdog
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result word: magnitude %0d phase %0d",
						result.signed_magnitude, result.phase);
					errors++;
				end else begin
					exp_res = pending_results.pop_front();
					if (result.signed_magnitude !== exp_res.signed_magnitude) begin
						$error("signed_magnitude: expected %0d, got %0d",
							exp_res.signed_magnitude, result.signed_magnitude);
						errors++;
					end
					if (result.phase !== exp_res.phase) begin
						$error("phase: expected %0d, got %0d", exp_res.phase, result.phase);
						errors++;
					end
					if (result.was_negated !== exp_res.was_negated) begin
						$error("was_negated: expected %0d, got %0d",
							exp_res.was_negated, result.was_negated);
						errors++;
					end
				end
			end
			if ((push && !full) || (pop && !empty) || (psel && penable)) stuck_cycles = 0;
			else stuck_cycles++;
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				stall_left = pick_gap();
			end
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t   script[$];
		item_t       w;
		int          random_words, phase, phase_words, len, mode, level;
		logic [31:0] v_coeff, v_cos, v_sin, v_ref;
		bit          more;

		regs.coeff = '0;
		regs.cosine = TRIG_BITS'(65536);
		regs.sine = '0;
		regs.ref_phase = '0;
		q_one = '0;
		q_two = '0;

		// Directed rows under reset settings first, then extreme registers
		script.push_back(sample_row(0, 1, 1'b1, SILENT));      // zero vector
		script.push_back(sample_row(4095, 1, 1'b0, SILENT));   // phase on the reference
		script.push_back(sample_row(0, 0, 1'b0, SILENT));
		script.push_back(sample_row(0, 1, 1'b1, SILENT));
		script.push_back(sample_row(4095, 0, 1'b0, SILENT));   // negative real: phase at pi
		script.push_back(sample_row(0, 1, 1'b0, SILENT));
		script.push_back(sample_row('hAAA, 0, 1'b0, SILENT));
		script.push_back(sample_row('h555, 1, 1'b0, SILENT));
		script.push_back(reg_row(REG_REF, 32767));
		script.push_back(sample_row(4095, 0, 1'b0, SILENT));   // -pi against +pi, no wrap
		script.push_back(sample_row(0, 1, 1'b0, SILENT));
		script.push_back(reg_row(REG_COEFF, 262143));
		script.push_back(reg_row(REG_COSINE, -131072));
		script.push_back(reg_row(REG_SINE, 131071));
		script.push_back(sample_row(4095, 0, 1'b0, SILENT));
		script.push_back(sample_row(4095, 0, 1'b0, SILENT));
		script.push_back(sample_row(4095, 0, 1'b0, SILENT));
		script.push_back(sample_row(4095, 1, 1'b0, SILENT));
		script.push_back(reg_row(REG_COEFF, -262144));
		script.push_back(reg_row(REG_SINE, -131072));
		script.push_back(reg_row(REG_REF, -32768));
		script.push_back(sample_row(1, 0, 1'b0, SILENT));
		script.push_back(sample_row(4095, 0, 1'b0, SILENT));
		script.push_back(sample_row(2048, 1, 1'b0, SILENT));
		script.push_back(sample_row(0, 1, 1'b1, SILENT));      // cleared state: zero vector

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed rows
		foreach (script[i]) begin
			if (script[i].is_write) begin
				if (i == 0 || !script[i-1].is_write) quiesce();
				more = (i + 1 < script.size()) && script[i+1].is_write;
				write_reg(script[i].reg_sel, script[i].value, more);
			end else begin
				feed_word(script[i].word, script[i].known, script[i].known_res);
			end
		end

		// Random phases: new register set, then whole blocks of random content
		random_words = 0;
		phase = 0;
		while (random_words < RANDOM_WORDS) begin
			quiesce();
			case (phase)
				0: begin
					v_coeff = -262144; v_cos = -131072; v_sin = -131072; v_ref = -32768;
				end
				1: begin
					v_coeff = 262143; v_cos = 131071; v_sin = 131071; v_ref = 32767;
				end
				2: begin
					v_coeff = 131072; v_cos = 65536; v_sin = -65536; v_ref = 16384;
				end
				3: begin
					v_coeff = 92682; v_cos = 46341; v_sin = 46341; v_ref = pick_reg_value(16);
				end
				4: begin
					v_coeff = 0; v_cos = 0; v_sin = 65536; v_ref = pick_reg_value(16);
				end
				5: begin
					v_coeff = 128553; v_cos = 64277; v_sin = 12785; v_ref = 32767;
				end
				default: begin
					v_coeff = pick_reg_value(COEFF_BITS);
					v_cos = pick_reg_value(TRIG_BITS);
					v_sin = pick_reg_value(TRIG_BITS);
					v_ref = pick_reg_value(ANGLE_BITS);
				end
			endcase
			write_reg(REG_COEFF, v_coeff, 1'b1);
			write_reg(REG_COSINE, v_cos, 1'b1);
			write_reg(REG_SINE, v_sin, 1'b1);
			write_reg(REG_REF, v_ref, 1'b0);
			calm = ($urandom_range(0, 3) == 0);

			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 300)
					: $urandom_range(1, 16);
				mode = $urandom_range(0, 3);
				level = $urandom_range(0, 4095);
				for (int k = 0; k < len; k++) begin
					case (mode)
						0:       w.sample = SAMPLE_BITS'($urandom_range(0, 4095));
						1:       w.sample = SAMPLE_BITS'(level);
						2:       w.sample = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
						default: w.sample = (k % 2) ? 12'h555 : 12'hAAA;
					endcase
					w.last_sample = (k == len - 1);
					feed_word(w, 1'b0, SILENT);
				end
				phase_words += len;
			end
			random_words += phase_words;
			phase++;
		end

		quiesce();
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/gstd_pkg.sv
rtl/gstd_front.sv
rtl/gstd_queue.sv
rtl/gstd_back.sv
rtl/goertzel_signed_tone_detector.sv
tb/sv/tb_top.sv
